FILE: design/rsc_pkg.sv
// Shared types, constants and a helper function of the radix string converter.
package rsc_pkg;

    // Radix codes of the two configuration registers
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SOURCE_BASE = 1'b0;
    localparam logic CFG_TARGET_BASE = 1'b1;

    // ASCII anchors and digit limits
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_UPA   = 8'd65;
    localparam logic [7:0] ASCII_UPF   = 8'd70;
    localparam logic [7:0] ASCII_ALPHA = 8'd55;
    localparam int         MAX_DIGITS  = 32;
    localparam int         CNT_W       = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POW2,
        S_DIV,
        S_EMIT
    } t_state;

    // Digit value 0..15 to its ASCII character
    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] ext;
        ext = {4'd0, d};
        if (d < 4'd10) begin
            digit_to_ascii = ext + ASCII_ZERO;
        end else begin
            digit_to_ascii = ext + ASCII_ALPHA;
        end
    endfunction

endpackage

FILE: design/radix_string_converter_top.sv
// Top level of the radix string converter: parser, digit generator and output stage.
//
// Input channel (i_s_*): one ASCII character per item, i_s_tlast on the final
// character of a string. Characters fold into a VALUE_WIDTH-bit accumulator in
// the source radix in the cycle they are accepted, one character per cycle while idle.
// Output channel (o_m_*): the value as ASCII digits in the target radix, most
// significant first, o_m_tlast on the final digit. Equal source and target
// radix codes give no output for that string.
// Configuration: write i_cfg_data into register i_cfg_addr (0 source radix,
// 1 target radix) while the block is idle.
// After the last character, digits are generated least significant first into
// a digit stack: one digit per step for binary, octal and hex targets, and for a
// decimal target one reciprocal divide-by-ten step per 16-bit slice of the value
// (two slices at the default width) per digit. The stack then drains at one
// digit per cycle while the receiver is ready, and o_s_tready stays low until
// the run has drained from the stack.
// i_rst_n (synchronous, active low) clears the accumulator, the stop flag and
// the output valid, and sets the radix codes to decimal in, hex out.
// A stalled receiver holds the output register; the stack waits behind it.
module radix_string_converter_top
    import rsc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [1:0] i_cfg_data,
    // input characters
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tlast,   // last_char
    // output digits
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] digit_char
    output logic       o_m_tlast    // last_digit
);

    // Divide by ten 16 bits at a time, most significant slice first
    localparam int CHUNK_W = 16;
    localparam int N_CHUNK = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int DIV_W   = N_CHUNK * CHUNK_W;
    localparam int CH_W    = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(N_CHUNK - 1);
    // ceil(2^23 / 10): exact quotient for every partial dividend below 2^22
    localparam logic [19:0] RECIP_TEN = 20'hCCCCD;

    t_state r_state, n_state;

    logic [1:0]             r_src_base;
    logic [1:0]             r_dst_base;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_stop;
    logic [3:0]             r_rem;
    logic [CH_W-1:0]        r_bit;
    logic [CNT_W-1:0]       r_cnt;
    logic [3:0]             r_stk [MAX_DIGITS];
    logic                   r_mvalid;
    logic [7:0]             r_mdata;
    logic                   r_mlast;

    // handshake and sequencer controls
    logic w_accept;
    logic w_out_free;
    logic w_push;
    logic w_pop;
    logic w_run_done;

    // parser
    logic                   w_is_dec;
    logic                   w_is_hex;
    logic                   w_take;
    logic                   w_stop_set;
    logic [3:0]             w_in_digit;
    logic [VALUE_WIDTH-1:0] w_scaled;
    logic [VALUE_WIDTH-1:0] w_folded;
    logic [7:0]             w_hex_off;

    // shared digit unit
    logic [DIV_W-1:0]       w_acc_ext;
    logic [CHUNK_W-1:0]     w_chunk;
    logic [19:0]            w_part;
    logic [39:0]            w_prod;
    logic [CHUNK_W-1:0]     w_quo;
    logic [19:0]            w_quo_ten;
    logic [19:0]            w_part_rem;
    logic [DIV_W-1:0]       w_div_ext;
    logic [3:0]             w_div_rem;
    logic [VALUE_WIDTH-1:0] w_div_acc;
    logic [3:0]             w_pow_digit;
    logic [VALUE_WIDTH-1:0] w_pow_acc;
    logic [3:0]             w_new_digit;
    logic [VALUE_WIDTH-1:0] w_new_acc;
    logic [CNT_W-1:0]       w_cnt_inc;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_mvalid || i_m_tready;

    // Parse one character: classify, pick its digit value, scale the accumulator
    always_comb begin
        w_is_dec   = i_s_tdata inside {[ASCII_ZERO:ASCII_NINE]};
        w_is_hex   = i_s_tdata inside {[ASCII_UPA:ASCII_UPF]};
        w_hex_off  = i_s_tdata - ASCII_ALPHA;
        w_in_digit = w_is_dec ? i_s_tdata[3:0] : w_hex_off[3:0];
        if (r_src_base == BASE_HEX) begin
            w_take     = w_is_dec || w_is_hex;
            w_stop_set = 1'b0;
        end else begin
            w_take     = !r_stop && w_is_dec;
            w_stop_set = !r_stop && !w_is_dec;
        end
        case (r_src_base)
            BASE_BIN: w_scaled = r_acc << 1;
            BASE_OCT: w_scaled = r_acc << 3;
            BASE_DEC: w_scaled = (r_acc << 3) + (r_acc << 1);
            default:  w_scaled = r_acc << 4;
        endcase
        w_folded = w_take ? w_scaled + {{(VALUE_WIDTH-4){1'b0}}, w_in_digit} : r_acc;
    end

    // Shared digit unit: one divide-by-ten step on a 16-bit slice, or a power-of-two split
    always_comb begin
        w_acc_ext  = DIV_W'(r_acc);
        w_chunk    = w_acc_ext[{r_bit, 4'd0} +: CHUNK_W];
        w_part     = {r_rem, w_chunk};
        w_prod     = w_part * RECIP_TEN;
        w_quo      = w_prod[38:23];
        w_quo_ten  = {1'b0, w_quo, 3'd0} + {3'd0, w_quo, 1'b0};
        w_part_rem = w_part - w_quo_ten;
        w_div_rem  = w_part_rem[3:0];
        // Replace the current slice with its quotient
        w_div_ext  = w_acc_ext;
        for (int i = 0; i < N_CHUNK; i++) begin
            if (CH_W'(i) == r_bit) begin
                w_div_ext[i*CHUNK_W +: CHUNK_W] = w_quo;
            end
        end
        w_div_acc  = w_div_ext[VALUE_WIDTH-1:0];
        case (r_dst_base)
            BASE_BIN: begin
                w_pow_digit = {3'd0, r_acc[0]};
                w_pow_acc   = r_acc >> 1;
            end
            BASE_OCT: begin
                w_pow_digit = {1'b0, r_acc[2:0]};
                w_pow_acc   = r_acc >> 3;
            end
            default: begin
                w_pow_digit = r_acc[3:0];
                w_pow_acc   = r_acc >> 4;
            end
        endcase
        if (r_state == S_DIV) begin
            w_new_digit = w_div_rem;
            w_new_acc   = w_div_acc;
        end else begin
            w_new_digit = w_pow_digit;
            w_new_acc   = w_pow_acc;
        end
        w_cnt_inc  = r_cnt + CNT_W'(1);
        w_run_done = (w_new_acc == '0) || (w_cnt_inc == CNT_W'(MAX_DIGITS));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_s_tlast && (r_src_base != r_dst_base)) begin
                    n_state = (r_dst_base == BASE_DEC) ? S_DIV : S_POW2;
                end
            end
            S_POW2: begin
                if (w_run_done) begin
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if ((r_bit == '0) && w_run_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && (r_cnt == CNT_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_POW2: w_push     = 1'b1;
            S_DIV:  w_push     = (r_bit == '0);
            S_EMIT: w_pop      = w_out_free;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_src_base <= BASE_DEC;
            r_dst_base <= BASE_HEX;
            r_acc      <= '0;
            r_stop     <= 1'b0;
            r_cnt      <= '0;
            r_mvalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_SOURCE_BASE) begin
                    r_src_base <= i_cfg_data;
                end else begin
                    r_dst_base <= i_cfg_data;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_s_tlast) begin
                            // Hand the value to the digit unit, or drop it on equal radix
                            r_acc  <= (r_src_base != r_dst_base) ? w_folded : '0;
                            r_stop <= 1'b0;
                        end else begin
                            r_acc  <= w_folded;
                            r_stop <= r_stop || w_stop_set;
                        end
                    end
                end
                S_POW2: begin
                    r_cnt <= w_cnt_inc;
                    r_acc <= w_run_done ? '0 : w_new_acc;
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        r_cnt <= w_cnt_inc;
                        r_acc <= w_run_done ? '0 : w_new_acc;
                    end else begin
                        r_acc <= w_new_acc;
                    end
                end
                S_EMIT: begin
                    if (w_pop) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                default: r_acc <= '0;
            endcase

            if (w_pop) begin
                r_mvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // Divider slice counter and partial remainder
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && (r_bit != '0)) begin
            r_bit <= r_bit - CH_W'(1);
            r_rem <= w_div_rem;
        end else begin
            r_bit <= CH_LAST;
            r_rem <= 4'd0;
        end
    end

    // Digit stack: push shifts up, pop shifts down; entry 0 is the top
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stk[0] <= w_new_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (w_pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_mdata <= digit_to_ascii(r_stk[0]);
            r_mlast <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tlast  = r_mlast;

endmodule

FILE: design/rsc_checker.sv
// Port-level assertions for the radix string converter, bound to the top level.
module rsc_checker
    import rsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // Hold off new characters while digits of a run are still pending
    a_busy_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input ready while a digit run is pending");

    // A character that is not last never starts output
    a_no_early_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tlast && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("output appeared after a non-last character");

    // Stalled digit holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output changed under stall");

    // Every emitted character is a digit 0-9 or A-F
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata >= ASCII_ZERO && o_m_tdata <= ASCII_NINE) ||
                        (o_m_tdata >= ASCII_UPA && o_m_tdata <= ASCII_UPF)))
        else $error("output character is not a digit");

endmodule

bind radix_string_converter_top rsc_checker u_rsc_checker (.*);

FILE: test/rsc_stream_checker.sv
// Watches the converter's channels, predicts the digit stream of each string and compares it.
`timescale 1ns / 1ps
module rsc_stream_checker
    import rsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [1:0] i_cfg_data,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tlast,   // last_char
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] digit_char
    input  logic       i_m_tlast,   // last_digit
    output int         o_fail_count,
    output int         o_pending,
    output int         o_digits_seen
);

    typedef struct packed {
        logic [7:0] digit_char;
        logic       last_digit;
    } t_digit_exp;

    t_digit_exp  expected_digits[$];
    logic [31:0] running_value;
    logic        stop_seen;
    logic [1:0]  src_code;
    logic [1:0]  tgt_code;
    int          fails;
    int          seen;

    function automatic logic [4:0] radix_of(input logic [1:0] code);
        case (code)
            BASE_BIN: return 5'd2;
            BASE_OCT: return 5'd8;
            BASE_DEC: return 5'd10;
            default:  return 5'd16;
        endcase
    endfunction

    task automatic fold_char(input logic [7:0] c);
        logic [31:0] digit;
        logic        counts;
        counts = 1'b0;
        digit  = '0;
        if (src_code == BASE_HEX) begin
            if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
                digit  = c - ASCII_ZERO;
                counts = 1'b1;
            end else if (c >= ASCII_UPA && c <= ASCII_UPF) begin
                digit  = c - ASCII_ALPHA;
                counts = 1'b1;
            end
        end else if (!stop_seen) begin
            if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
                digit  = c - ASCII_ZERO;
                counts = 1'b1;
            end else begin
                stop_seen = 1'b1;
            end
        end
        if (counts) begin
            running_value = running_value * radix_of(src_code) + digit;
        end
    endtask

    // The division yields digits least significant first, so collect them and queue in reverse.
    task automatic predict_digits();
        logic [31:0] v;
        logic [31:0] d;
        logic [4:0]  r;
        logic [7:0]  lsd_first[$];
        int          n;
        v = running_value;
        r = radix_of(tgt_code);
        n = 0;
        do begin
            d = v % r;
            lsd_first.push_back(d < 10 ? ASCII_ZERO + d[7:0] : ASCII_UPA + d[7:0] - 8'd10);
            v = v / r;
            n++;
        end while (v != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            expected_digits.push_back('{digit_char: lsd_first[k], last_digit: (k == 0)});
        end
    endtask

    always @(posedge i_clk) begin
        t_digit_exp want;
        if (!i_rst_n) begin
            expected_digits.delete();
            running_value = '0;
            stop_seen     = 1'b0;
            src_code      = BASE_DEC;
            tgt_code      = BASE_HEX;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_SOURCE_BASE) begin
                    src_code = i_cfg_data;
                end else begin
                    tgt_code = i_cfg_data;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                seen++;
                if (expected_digits.size() == 0) begin
                    $error("digit_char: unexpected item, got %h (last_digit %b)",
                           i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want = expected_digits.pop_front();
                    if (i_m_tdata !== want.digit_char) begin
                        $error("digit_char: expected %h, got %h", want.digit_char, i_m_tdata);
                        fails++;
                    end
                    if (i_m_tlast !== want.last_digit) begin
                        $error("last_digit: expected %b, got %b", want.last_digit, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fold_char(i_s_tdata);
                if (i_s_tlast) begin
                    if (src_code != tgt_code) begin
                        predict_digits();
                    end
                    running_value = '0;
                    stop_seen     = 1'b0;
                end
            end
        end
        o_pending     <= expected_digits.size();
        o_fail_count  <= fails;
        o_digits_seen <= seen;
    end

endmodule

FILE: test/tb_radix_string_converter_top.sv
// Stimulus, handshake idling and verdict for the radix string converter.
`timescale 1ns / 1ps
module tb_radix_string_converter_top;
    import rsc_pkg::*;

    // Quiet-cycle limit: long enough to cover digit generation before a run's first
    // digit, the config pause and the longest receiver stall.
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_ITEMS  = 480;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_addr = 1'b0;
    logic [1:0] i_cfg_data = 2'd0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'd0;   // [7:0] char_code
    logic       i_s_tlast = 1'b0;   // last_char
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // [7:0] digit_char
    logic       o_m_tlast;          // last_digit

    int         fail_count;
    int         pending_digits;
    int         digits_seen;
    int         quiet_cycles = 0;
    int         stall_left = 0;
    logic       tx_pressure = 1'b0;
    logic       rx_pressure = 1'b0;
    logic [1:0] src_now = BASE_DEC;
    logic [1:0] tgt_now = BASE_HEX;
    int         chars_sent = 0;
    int         strings_sent = 0;
    int         settings_used = 1;

    radix_string_converter_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    rsc_stream_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_digits),
        .o_digits_seen(digits_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: a short gap 85 percent of the time, else a long one.
    function automatic int draw_gap();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Receiver: drop tready for random stretches while rx_pressure is on.
    always @(negedge i_clk) begin
        if (stall_left == 0 && rx_pressure && $urandom_range(99) < 25) begin
            stall_left = draw_gap();
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[radix_string_converter_top] ERROR");
            $finish;
        end
    end

    // Offer one character, with an optional gap before it, and hold until taken.
    task automatic send_char(input logic [7:0] c, input logic lst);
        int gap;
        gap = (tx_pressure && $urandom_range(99) < 30) ? draw_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
        if (lst) begin
            strings_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Drain every expected digit, let a silent conversion finish, then write both radixes.
    task automatic set_radix(input logic [1:0] src, input logic [1:0] tgt);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_digits != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_SOURCE_BASE;
        i_cfg_data <= src;
        @(negedge i_clk);
        i_cfg_addr <= CFG_TARGET_BASE;
        i_cfg_data <= tgt;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        src_now = src;
        tgt_now = tgt;
        settings_used++;
    endtask

    // Mostly digits valid for the source radix; some out-of-radix digits and noise.
    function automatic logic [7:0] pick_char(input logic [1:0] src);
        int r;
        int d;
        r = $urandom_range(99);
        if (r < 8) begin
            return 8'($urandom_range(0, 255));
        end
        if (src == BASE_HEX) begin
            if (r < 14) begin
                return 8'd97 + 8'($urandom_range(0, 5));
            end
            d = $urandom_range(0, 15);
            return d < 10 ? ASCII_ZERO + 8'(d) : ASCII_UPA + 8'(d - 10);
        end
        if (r < 18 || src == BASE_DEC) begin
            return ASCII_ZERO + 8'($urandom_range(0, 9));
        end
        return ASCII_ZERO + 8'($urandom_range(0, src == BASE_BIN ? 1 : 7));
    endfunction

    task automatic send_random_string();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 80) begin
            len = $urandom_range(1, 10);
        end else if (r < 95) begin
            len = $urandom_range(11, 20);
        end else begin
            len = $urandom_range(21, 34);   // long enough to wrap the accumulator
        end
        for (int i = 0; i < len; i++) begin
            send_char(pick_char(src_now), i == len - 1);
        end
    endtask

    initial begin
        logic [1:0] corner_src[5];
        logic [1:0] corner_tgt[5];
        int         phase;
        int         start_chars;
        corner_src = '{BASE_BIN, BASE_HEX, BASE_HEX, BASE_BIN, BASE_DEC};
        corner_tgt = '{BASE_HEX, BASE_BIN, BASE_DEC, BASE_DEC, BASE_BIN};

        // Hold reset low from the start, then release it at a falling edge.
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset radixes (decimal in, hex out): zero, and a string cut by a non-digit.
        send_text("0");
        send_text("12a3");
        // Hex in, binary out: skipped noise and lowercase, then the widest value.
        set_radix(BASE_HEX, BASE_BIN);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char("f", 1'b0);
        send_text("FFFFFFFF");
        // Binary in with digits above the radix, decimal out.
        set_radix(BASE_BIN, BASE_DEC);
        send_text("99");
        // Equal radixes: the string yields nothing.
        set_radix(BASE_OCT, BASE_OCT);
        send_text("7");

        // Random phases: the corner radix pairs first, then random ones.
        start_chars = chars_sent;
        phase = 0;
        while (chars_sent - start_chars < RANDOM_ITEMS) begin
            if (phase < 5) begin
                set_radix(corner_src[phase], corner_tgt[phase]);
            end else begin
                set_radix(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end
            tx_pressure = ($urandom_range(0, 3) != 0);
            rx_pressure = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) send_random_string();
            phase++;
        end

        // Drop valid, drain the output, then allow for a late or stray digit.
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_digits != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d strings (%0d characters) under %0d radix settings.",
                 strings_sent, chars_sent, settings_used);
        $display("Checked %0d output digits; %0d digits still awaited.",
                 digits_seen, pending_digits);
        if (fail_count == 0 && pending_digits == 0) begin
            $display("[radix_string_converter_top] OK");
        end else begin
            $display("[radix_string_converter_top] ERROR");
        end
        $finish;
    end

endmodule
